FILE: rtl/cia_pkg.sv
`timescale 1ns / 1ps

package cia_pkg;

  localparam int NUM_THRESHOLDS_DEF = 4;
  localparam int COUNT_WIDTH_DEF    = 48;

  // Breadth outputs that the result channel carries
  localparam int OUT_BREADTHS = 4;

  localparam int POS_W      = 32;
  localparam int THR_W      = 31;
  localparam int ACT_W      = 3;
  localparam int SUM_W      = 64;
  localparam int PROD_W     = THR_W + POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int QUEUE_DEPTH = 2;

  // Register indexes; threshold k sits at CFG_THRESHOLD_0 + k
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE      = 3'd4;

  // Classified record as it travels from the front end to the accumulators
  typedef struct packed {
    logic [POS_W-1:0]        len;
    logic [THR_W-1:0]        depth;
    logic                    rejected;
    logic                    zero_depth;
    logic [OUT_BREADTHS-1:0] hits;
  } cia_item_t;

  function automatic int num_used(int n);
    return (n < OUT_BREADTHS) ? n : OUT_BREADTHS;
  endfunction

endpackage

FILE: rtl/cia_if.sv
`timescale 1ns / 1ps

interface cia_rec_if;
  logic                      valid;
  logic                      ready;
  logic [cia_pkg::POS_W-1:0] start_pos;
  logic [cia_pkg::POS_W-1:0] end_pos;
  logic [cia_pkg::POS_W-1:0] depth;

  modport source (output valid, output start_pos, output end_pos, output depth,
                  input ready);
  modport sink (input valid, input start_pos, input end_pos, input depth,
                output ready);
endinterface

interface cia_res_if #(
  parameter int COUNT_WIDTH = cia_pkg::COUNT_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [COUNT_WIDTH-1:0]    positions_total;
  logic [cia_pkg::SUM_W-1:0] depth_sum;
  logic [COUNT_WIDTH-1:0]    empty_bases;
  logic [COUNT_WIDTH-1:0]    gap_count;
  logic [COUNT_WIDTH-1:0]    breadth_count_0;
  logic [COUNT_WIDTH-1:0]    breadth_count_1;
  logic [COUNT_WIDTH-1:0]    breadth_count_2;
  logic [COUNT_WIDTH-1:0]    breadth_count_3;
  logic                      record_rejected;
  logic                      error_seen;

  modport source (output valid, output positions_total, output depth_sum,
                  output empty_bases, output gap_count, output breadth_count_0,
                  output breadth_count_1, output breadth_count_2,
                  output breadth_count_3, output record_rejected,
                  output error_seen, input ready);
  modport sink (input valid, input positions_total, input depth_sum,
                input empty_bases, input gap_count, input breadth_count_0,
                input breadth_count_1, input breadth_count_2,
                input breadth_count_3, input record_rejected,
                input error_seen, output ready);
endinterface

FILE: rtl/coverage_interval_accumulator.sv
`timescale 1ns / 1ps
// Coverage interval accumulator.
// Input channel rec carries one interval record per transaction: start_pos,
// end_pos (exclusive) and depth. Output channel res returns one transaction
// per record with the running totals after that record: positions, depth sum,
// zero-depth bases and gaps, four breadth counts, a reject flag for this
// record and the sticky error flag. All counters saturate.
// Thresholds and the active threshold count are written through the plain
// write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them
// only while no record is in flight, as the block does not enforce it.
// An accepted record passes the queue, the multiply stage and the accumulate
// into the result register. Throughput: one record per cycle unless res
// stalls; the accumulator feedback is a single saturating add per counter
// and the 31x32 product has its own stage. When res stalls, the result and
// the multiply stage hold, the two-entry queue fills and then rec.ready
// drops; the front end keeps accepting until the queue is full.
// Reset clears all totals, the error flag, thresholds and the active count.
module coverage_interval_accumulator #(
  parameter int NUM_THRESHOLDS = cia_pkg::NUM_THRESHOLDS_DEF,
  parameter int COUNT_WIDTH    = cia_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cia_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cia_rec_if.sink                        rec,
  cia_res_if.source                      res
);
  import cia_pkg::*;

  logic      push;
  logic      q_ready;
  logic      q_valid;
  logic      pop;
  cia_item_t push_item;
  cia_item_t head_item;

  cia_front #(
    .NUM_THRESHOLDS(NUM_THRESHOLDS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rec       (rec),
    .push_o    (push),
    .item_o    (push_item),
    .q_ready_i (q_ready)
  );

  cia_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .item_o (head_item),
    .pop_i  (pop)
  );

  cia_back #(
    .NUM_THRESHOLDS(NUM_THRESHOLDS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_item_i (head_item),
    .pop_o    (pop),
    .res      (res)
  );

`ifndef NO_ASSERTIONS
  a_sticky_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.error_seen |=> res.error_seen)
    else $error("error flag cleared after being set");

  a_reject_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.record_rejected) |-> res.error_seen)
    else $error("rejected record without error flag");

  a_pos_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (res.positions_total >= $past(res.positions_total)))
    else $error("position total decreased");

  a_gap_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.empty_bases <= res.positions_total)
    else $error("zero-depth bases exceed total positions");
`endif

endmodule

FILE: rtl/cia_front.sv
`timescale 1ns / 1ps

module cia_front #(
  parameter int NUM_THRESHOLDS = cia_pkg::NUM_THRESHOLDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cia_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cia_rec_if.sink                        rec,
  output logic                           push_o,
  output cia_pkg::cia_item_t             item_o,
  input  logic                           q_ready_i
);
  import cia_pkg::*;

  localparam int NumUsed = num_used(NUM_THRESHOLDS);

  logic [THR_W-1:0] thr_q [NumUsed];
  logic [ACT_W-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int k = 0; k < NumUsed; k++) begin
        thr_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ACTIVE) begin
        active_q <= cfg_data_i[ACT_W-1:0];
      end
      for (int k = 0; k < NumUsed; k++) begin
        if (cfg_idx_i == CFG_THRESHOLD_0 + CFG_IDX_W'(k)) begin
          thr_q[k] <= cfg_data_i[THR_W-1:0];
        end
      end
    end
  end

  assign rec.ready = q_ready_i;
  assign push_o    = rec.valid & q_ready_i;

  // Classify: length, reject, gap and per-threshold hits
  always_comb begin
    item_o            = '0;
    item_o.len        = (rec.end_pos > rec.start_pos) ? (rec.end_pos - rec.start_pos) : '0;
    item_o.depth      = rec.depth[THR_W-1:0];
    item_o.rejected   = rec.depth[POS_W-1];
    item_o.zero_depth = (rec.depth == '0);
    for (int k = 0; k < NumUsed; k++) begin
      item_o.hits[k] = (ACT_W'(k) < active_q) && (rec.depth >= {1'b0, thr_q[k]});
    end
  end

endmodule

FILE: rtl/cia_queue.sv
`timescale 1ns / 1ps

module cia_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cia_pkg::cia_item_t item_i,
  output logic               ready_o,
  output logic               valid_o,
  output cia_pkg::cia_item_t item_o,
  input  logic               pop_i
);
  import cia_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  cia_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [PtrW:0]   cnt_q;

  assign ready_o = (cnt_q != (PtrW + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/cia_back.sv
`timescale 1ns / 1ps

module cia_back #(
  parameter int NUM_THRESHOLDS = cia_pkg::NUM_THRESHOLDS_DEF,
  parameter int COUNT_WIDTH    = cia_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cia_pkg::cia_item_t q_item_i,
  output logic               pop_o,
  cia_res_if.source          res
);
  import cia_pkg::*;

  localparam int NumUsed = num_used(NUM_THRESHOLDS);

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(logic [COUNT_WIDTH-1:0] acc,
                                                     logic [POS_W-1:0] inc);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, acc} + (COUNT_WIDTH + 1)'(inc);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // Multiply stage
  logic              a_valid_q;
  cia_item_t         a_item_q;
  logic [PROD_W-1:0] a_prod_q;
  logic              a_ready;
  logic              b_load;

  // Accumulators double as the result register
  logic                   out_valid_q;
  logic                   rej_q;
  logic                   err_q;
  logic [COUNT_WIDTH-1:0] pos_q;
  logic [COUNT_WIDTH-1:0] empty_q;
  logic [COUNT_WIDTH-1:0] gap_q;
  logic [SUM_W-1:0]       dsum_q;
  logic [COUNT_WIDTH-1:0] brd_q [NumUsed];
  logic [COUNT_WIDTH-1:0] brd_out [OUT_BREADTHS];
  logic [SUM_W:0]         dsum_add;

  assign b_load  = a_valid_q && (!out_valid_q || res.ready);
  assign a_ready = !a_valid_q || b_load;
  assign pop_o   = q_valid_i && a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_item_q <= q_item_i;
      a_prod_q <= q_item_i.depth * q_item_i.len;
    end
  end

  assign dsum_add = {1'b0, dsum_q} + (SUM_W + 1)'(a_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rej_q       <= 1'b0;
      err_q       <= 1'b0;
      pos_q       <= '0;
      empty_q     <= '0;
      gap_q       <= '0;
      dsum_q      <= '0;
      for (int k = 0; k < NumUsed; k++) begin
        brd_q[k] <= '0;
      end
    end else begin
      if (b_load) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
      if (b_load) begin
        rej_q <= a_item_q.rejected;
        err_q <= err_q | a_item_q.rejected;
        // A rejected record leaves every total where it was
        if (!a_item_q.rejected) begin
          pos_q  <= sat_cnt(pos_q, a_item_q.len);
          dsum_q <= dsum_add[SUM_W] ? '1 : dsum_add[SUM_W-1:0];
          if (a_item_q.zero_depth) begin
            gap_q   <= sat_cnt(gap_q, POS_W'(1));
            empty_q <= sat_cnt(empty_q, a_item_q.len);
          end
          for (int k = 0; k < NumUsed; k++) begin
            if (a_item_q.hits[k]) begin
              brd_q[k] <= sat_cnt(brd_q[k], a_item_q.len);
            end
          end
        end
      end
    end
  end

  for (genvar k = 0; k < OUT_BREADTHS; k++) begin : g_brd
    if (k < NumUsed) begin : g_used
      assign brd_out[k] = brd_q[k];
    end else begin : g_unused
      assign brd_out[k] = '0;
    end
  end

  assign res.valid           = out_valid_q;
  assign res.positions_total = pos_q;
  assign res.depth_sum       = dsum_q;
  assign res.empty_bases     = empty_q;
  assign res.gap_count       = gap_q;
  assign res.breadth_count_0 = brd_out[0];
  assign res.breadth_count_1 = brd_out[1];
  assign res.breadth_count_2 = brd_out[2];
  assign res.breadth_count_3 = brd_out[3];
  assign res.record_rejected = rej_q;
  assign res.error_seen      = err_q;

endmodule
